@@ rtl/joint_angle_rep_phase_tracker_macros.svh @@
// assertion macros used by the tracker controller
`ifndef JOINT_ANGLE_REP_PHASE_TRACKER_MACROS_SVH
`define JOINT_ANGLE_REP_PHASE_TRACKER_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define JART_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define JART_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/jart_pkg.sv @@
`default_nettype none
package jart_pkg;

  localparam int DEF_COORD_WIDTH  = 16;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_LEN         = 24;
  localparam int STEP_W           = 5;
  localparam int NORM_BIT         = 40;
  localparam int QUOT_BITS        = 11;

  localparam int ANGLE_MAX   = 1800;
  localparam int F_MAX       = ANGLE_MAX * 256;
  localparam int NEAR_BAND   = 100;
  localparam int LEAVE_BAND  = 150;
  localparam int RETURN_BAND = 120;
  localparam int QUARTER_Q16 = 90 * 65536;

  localparam int FAST_MS    = 1200;
  localparam int SLOW_MS    = 5000;
  localparam int TEMPO_FAST = 400;
  localparam int TEMPO_SLOW = 425;
  localparam int TEMPO_NORM = 500;
  localparam int W_ACH      = 1500;
  localparam int W_PARTIAL  = 1400;
  localparam int W_GOOD     = 1700;
  localparam int SCORE_MAX  = 1000;
  localparam int CNT_MAX    = 65535;

  typedef enum logic [1:0] {
    PH_START, PH_MOVING, PH_INFLECTION, PH_RETURNING
  } phase_t;

  typedef enum logic [1:0] {
    RT_PERFECT, RT_GOOD, RT_PARTIAL
  } rating_t;

  typedef enum logic [2:0] {
    REG_EXT, REG_CONT, REG_MIN, REG_MAX, REG_ROM, REG_ALPHA
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] ext;
    logic [10:0] cont;
    logic [15:0] min_ms;
    logic [15:0] max_ms;
    logic [10:0] rom;
    logic [8:0]  alpha;
  } cfg_t;

  typedef struct packed {
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [15:0] vertex_x;
    logic [15:0] vertex_y;
    logic [15:0] third_x;
    logic [15:0] third_y;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic        rep_done;
    logic [15:0] rep_count;
    logic [1:0]  phase;
    logic [10:0] smoothed_angle;
    logic [10:0] peak_angle;
    logic [10:0] start_angle;
    logic [15:0] rep_duration_ms;
    logic [9:0]  quality_score;
    logic [1:0]  form_rating;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL0, OP_MUL1, OP_MUL2, OP_MUL3, OP_MUL4, OP_PREP,
    OP_NORM, OP_ROT, OP_FIN, OP_EMA0, OP_EMA1, OP_UPD, OP_SC0, OP_SC1, OP_SC2,
    OP_DIV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic norm_done;
  } status_t;

  // atan(2^-i) in q16 degrees
  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/jart_ifs.sv @@
`default_nettype none
interface jart_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_x;
  logic signed [15:0] first_y;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic signed [15:0] third_x;
  logic signed [15:0] third_y;
  logic [31:0]        time_ms;
  modport source(output valid, first_x, first_y, vertex_x, vertex_y, third_x, third_y,
                 time_ms, input ready);
  modport sink(input valid, first_x, first_y, vertex_x, vertex_y, third_x, third_y,
               time_ms, output ready);
endinterface

interface jart_out_if;
  logic        valid;
  logic        ready;
  logic        rep_done;
  logic [15:0] rep_count;
  logic [1:0]  phase;
  logic [10:0] smoothed_angle;
  logic [10:0] peak_angle;
  logic [10:0] start_angle;
  logic [15:0] rep_duration_ms;
  logic [9:0]  quality_score;
  logic [1:0]  form_rating;
  modport source(output valid, rep_done, rep_count, phase, smoothed_angle, peak_angle,
                 start_angle, rep_duration_ms, quality_score, form_rating, input ready);
  modport sink(input valid, rep_done, rep_count, phase, smoothed_angle, peak_angle,
               start_angle, rep_duration_ms, quality_score, form_rating, output ready);
endinterface
`default_nettype wire

@@ rtl/jart_cfg.sv @@
`default_nettype none
module jart_cfg import jart_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext    <= 11'd1500;
      cfg.cont   <= 11'd550;
      cfg.min_ms <= 16'd750;
      cfg.max_ms <= 16'd8000;
      cfg.rom    <= 11'd150;
      cfg.alpha  <= 9'd115;
    end else if (wr) begin
      case (paddr[4:2])
        REG_EXT:   cfg.ext    <= pwdata[10:0];
        REG_CONT:  cfg.cont   <= pwdata[10:0];
        REG_MIN:   cfg.min_ms <= pwdata[15:0];
        REG_MAX:   cfg.max_ms <= pwdata[15:0];
        REG_ROM:   cfg.rom    <= pwdata[10:0];
        REG_ALPHA: cfg.alpha  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_EXT:   prdata = {21'd0, cfg.ext};
      REG_CONT:  prdata = {21'd0, cfg.cont};
      REG_MIN:   prdata = {16'd0, cfg.min_ms};
      REG_MAX:   prdata = {16'd0, cfg.max_ms};
      REG_ROM:   prdata = {21'd0, cfg.rom};
      REG_ALPHA: prdata = {23'd0, cfg.alpha};
      default:   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/jart_dp.sv @@
`default_nettype none
module jart_dp import jart_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  cfg_t      cfg,
  input  in_item_t  in_item,
  output status_t   st,
  output out_item_t out_item
);

  localparam int CW = COORD_WIDTH;
  localparam int XW = (CW > 16) ? CW : 16;
  localparam int UW = CW + 1;
  localparam int PW = 2 * CW + 3;
  localparam int NW = ((PW > NORM_BIT + 1) ? PW : NORM_BIT + 1) + 3;
  localparam int ZW = 26;

  localparam logic signed [12:0] NEAR_S  = 13'(NEAR_BAND);
  localparam logic signed [12:0] LEAVE_S = 13'(LEAVE_BAND);
  localparam logic signed [12:0] RET_S   = 13'(RETURN_BAND);

  function automatic logic signed [CW-1:0] crd(input logic [15:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    return e[CW-1:0];
  endfunction

  // frame operands
  logic signed [UW-1:0]   ux, uy, vx, vy;
  logic [31:0]            time_r;
  logic signed [2*UW-1:0] prod, mp;
  logic signed [UW-1:0]   ma, mb;
  // cordic
  logic signed [NW-1:0]   x, y, xs, ys, yabs;
  logic signed [ZW-1:0]   z, at;
  logic [NW-1:0]          orv;
  logic [10:0]            raw;
  logic [24:0]            zc;
  logic [29:0]            zt;
  // smoothing
  logic [19:0]            f;
  logic                   seeded, seeding;
  logic signed [21:0]     ediff;
  logic signed [31:0]     eprod, ed;
  logic signed [32:0]     fn;
  logic [20:0]            fr;
  logic [10:0]            sm;
  // rep tracking
  phase_t                 phase, phase_next;
  logic [10:0]            start_a, peak_a, start_next, peak_next;
  logic [31:0]            rep_start_time, rst_time_next, elapsed;
  logic [15:0]            rep_duration, dur_next, rep_counter, cnt_next;
  logic                   done_r, done_next, inv;
  logic signed [12:0]     sa, se, sc, srm, speak;
  logic [8:0]             tempo2;
  // scoring
  logic signed [11:0]     dd, rr;
  logic [10:0]            ach0, tgt0, ach1, tgt, ach, tgt_r;
  logic [21:0]            m1, t14, t17;
  logic [19:0]            m2;
  logic [22:0]            num, dvd;
  logic [11:0]            rem, dv;
  logic [12:0]            r2;
  logic                   ge;
  logic [QUOT_BITS-1:0]   qd;
  logic [9:0]             last_score, score_new;
  rating_t                last_rating;
  out_item_t              out_r;

  assign orv          = x | y;
  assign st.norm_done = |orv[NW-1:NORM_BIT];
  assign st.degen     = (x == '0) && (y == '0);

  always_comb begin
    case (cmd.op)
      OP_MUL0: begin ma = ux; mb = vx; end
      OP_MUL1: begin ma = uy; mb = vy; end
      OP_MUL2: begin ma = ux; mb = vy; end
      default: begin ma = uy; mb = vx; end
    endcase
  end
  assign mp = ma * mb;

  assign yabs = y[NW-1] ? -y : y;
  assign xs   = x >>> cmd.idx;
  assign ys   = y >>> cmd.idx;
  assign at   = signed'(ZW'(atan_q16(cmd.idx)));
  assign zc   = z[ZW-1] ? 25'd0 : z[24:0];
  assign zt   = {2'b0, zc, 3'b0} + {4'b0, zc, 1'b0} + 30'd32768;

  assign ediff = signed'({3'b0, raw, 8'b0}) - signed'({2'b0, f});
  assign ed    = (eprod + 32'sd128) >>> 8;
  assign fn    = signed'({13'b0, f}) + 33'(ed);
  assign fr    = {1'b0, f} + 21'd128;
  assign sm    = (fr[20:8] > 13'(ANGLE_MAX)) ? 11'(ANGLE_MAX) : fr[18:8];

  assign inv     = cfg.cont > cfg.ext;
  assign sa      = signed'({2'b0, sm});
  assign se      = signed'({2'b0, cfg.ext});
  assign sc      = signed'({2'b0, cfg.cont});
  assign srm     = signed'({2'b0, cfg.rom});
  assign speak   = signed'({2'b0, peak_a});
  assign elapsed = time_r - rep_start_time;

  always_comb begin
    phase_next    = phase;
    start_next    = start_a;
    peak_next     = peak_a;
    rst_time_next = rep_start_time;
    dur_next      = rep_duration;
    cnt_next      = rep_counter;
    done_next     = 1'b0;
    if (phase != PH_START) begin
      dur_next = (|elapsed[31:16]) ? 16'hFFFF : elapsed[15:0];
    end
    case (phase)
      PH_START: begin
        if (inv ? (sa <= se + NEAR_S) : (sa >= se - NEAR_S)) begin
          start_next = sm;
          peak_next  = sm;
        end
        if (inv ? (sa > se + LEAVE_S) : (sa < se - LEAVE_S)) begin
          phase_next    = PH_MOVING;
          rst_time_next = time_r;
          peak_next     = sm;
        end
      end
      PH_MOVING: begin
        if (inv ? (sa > speak) : (sa < speak)) peak_next = sm;
        if (inv ? (sa >= sc) : (sa <= sc)) phase_next = PH_INFLECTION;
        else if (elapsed > {16'd0, cfg.max_ms}) phase_next = PH_START;
      end
      PH_INFLECTION: begin
        if (inv ? (sa > speak) : (sa < speak)) peak_next = sm;
        if (inv ? (sa < sc - RET_S) : (sa > sc + RET_S)) phase_next = PH_RETURNING;
      end
      PH_RETURNING: begin
        if (inv ? (sa <= se + srm) : (sa >= se - srm)) begin
          if (elapsed >= {16'd0, cfg.min_ms}) begin
            if (rep_counter != 16'(CNT_MAX)) cnt_next = rep_counter + 16'd1;
            done_next = 1'b1;
          end
          phase_next = PH_START;
        end else if (elapsed > {16'd0, cfg.max_ms}) begin
          phase_next = PH_START;
        end
      end
      default: ;
    endcase
  end

  assign dd   = signed'({1'b0, start_a}) - signed'({1'b0, peak_a});
  assign rr   = signed'({1'b0, cfg.ext}) - signed'({1'b0, cfg.cont});
  assign ach0 = dd[11] ? 11'(-dd) : dd[10:0];
  assign tgt0 = rr[11] ? 11'(-rr) : rr[10:0];
  assign tgt  = (tgt0 == 11'd0) ? 11'd1 : tgt0;
  assign ach1 = (tgt0 == 11'd0) ? 11'd1 : ach0;
  assign ach  = (ach1 > tgt) ? tgt : ach1;
  assign dvd  = num + 23'(tgt_r);
  assign dv   = {tgt_r, 1'b0};
  assign r2   = {rem, qd[QUOT_BITS-1]};
  assign ge   = r2 >= {1'b0, dv};
  assign score_new = !done_r ? last_score :
                     (qd > QUOT_BITS'(SCORE_MAX)) ? 10'(SCORE_MAX) : qd[9:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      f              <= '0;
      seeded         <= 1'b0;
      start_a        <= '0;
      peak_a         <= '0;
      rep_start_time <= '0;
      rep_duration   <= '0;
      rep_counter    <= '0;
      last_score     <= '0;
      last_rating    <= RT_PERFECT;
      done_r         <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          ux     <= UW'(crd(in_item.first_x)) - UW'(crd(in_item.vertex_x));
          uy     <= UW'(crd(in_item.first_y)) - UW'(crd(in_item.vertex_y));
          vx     <= UW'(crd(in_item.third_x)) - UW'(crd(in_item.vertex_x));
          vy     <= UW'(crd(in_item.third_y)) - UW'(crd(in_item.vertex_y));
          time_r <= in_item.time_ms;
        end
        OP_MUL0: prod <= mp;
        OP_MUL1: begin x <= NW'(prod); prod <= mp; end
        OP_MUL2: begin x <= x + NW'(prod); prod <= mp; end
        OP_MUL3: begin y <= NW'(prod); prod <= mp; end
        OP_MUL4: y <= y - NW'(prod);
        OP_PREP: begin
          if (x[NW-1]) begin
            x <= yabs;
            y <= -x;
            z <= ZW'(QUARTER_Q16);
          end else begin
            y <= yabs;
            z <= '0;
          end
        end
        OP_NORM: begin
          if (!st.norm_done) begin
            if (|orv[NW-1:32]) begin
              x <= x <<< 1;
              y <= y <<< 1;
            end else begin
              x <= x <<< 8;
              y <= y <<< 8;
            end
          end
        end
        OP_ROT: begin
          if (!y[NW-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end
        end
        OP_FIN: raw <= (zt[29:16] > 14'(ANGLE_MAX)) ? 11'(ANGLE_MAX) : zt[26:16];
        OP_EMA0: begin
          seeding <= !seeded;
          if (!seeded) begin
            f      <= {1'b0, raw, 8'b0};
            seeded <= 1'b1;
          end
          eprod <= 32'(ediff) * 32'(signed'({1'b0, cfg.alpha[8] ? 9'd256 : cfg.alpha}));
        end
        OP_EMA1: begin
          if (!seeding) begin
            if (fn[32]) f <= '0;
            else if (fn > 33'sd460800) f <= 20'(F_MAX);
            else f <= fn[19:0];
          end
        end
        OP_UPD: begin
          phase          <= phase_next;
          start_a        <= start_next;
          peak_a         <= peak_next;
          rep_start_time <= rst_time_next;
          rep_duration   <= dur_next;
          rep_counter    <= cnt_next;
          done_r         <= done_next;
          tempo2 <= (elapsed < 32'(FAST_MS)) ? 9'(TEMPO_FAST) :
                    (elapsed > 32'(SLOW_MS)) ? 9'(TEMPO_SLOW) : 9'(TEMPO_NORM);
        end
        OP_SC0: begin
          m1    <= 22'(ach) * 22'(W_ACH);
          m2    <= 20'(tgt) * 20'(tempo2);
          tgt_r <= tgt;
        end
        OP_SC1: begin
          num <= 23'(m1) + 23'(m2);
          t14 <= 22'(tgt_r) * 22'(W_PARTIAL);
          t17 <= 22'(tgt_r) * 22'(W_GOOD);
        end
        OP_SC2: begin
          rem <= dvd[22:QUOT_BITS];
          qd  <= dvd[QUOT_BITS-1:0];
          if (done_r) begin
            if (num < 23'(t14)) last_rating <= RT_PARTIAL;
            else if (num < 23'(t17)) last_rating <= RT_GOOD;
            else last_rating <= RT_PERFECT;
          end
        end
        OP_DIV: begin
          rem <= ge ? 12'(r2 - {1'b0, dv}) : r2[11:0];
          qd  <= {qd[QUOT_BITS-2:0], ge};
        end
        OP_EMIT: begin
          last_score            <= score_new;
          out_r.rep_done        <= done_r;
          out_r.rep_count       <= rep_counter;
          out_r.phase           <= phase;
          out_r.smoothed_angle  <= sm;
          out_r.peak_angle      <= peak_a;
          out_r.start_angle     <= start_a;
          out_r.rep_duration_ms <= rep_duration;
          out_r.quality_score   <= score_new;
          out_r.form_rating     <= last_rating;
        end
        default: ;
      endcase
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

@@ rtl/jart_ctrl.sv @@
`default_nettype none
`include "joint_angle_rep_phase_tracker_macros.svh"
module jart_ctrl import jart_pkg::*; #(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(NSTEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUOT_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_PREP, S_NORM, S_ROT,
    S_FIN, S_EMA0, S_EMA1, S_UPD, S_SC0, S_SC1, S_SC2, S_DIV, S_EMIT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              emit_go;

  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.idx = step;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_MUL0:  cmd.op = OP_MUL0;
      S_MUL1:  cmd.op = OP_MUL1;
      S_MUL2:  cmd.op = OP_MUL2;
      S_MUL3:  cmd.op = OP_MUL3;
      S_MUL4:  cmd.op = OP_MUL4;
      S_PREP:  cmd.op = OP_PREP;
      S_NORM:  cmd.op = OP_NORM;
      S_ROT:   cmd.op = OP_ROT;
      S_FIN:   cmd.op = OP_FIN;
      S_EMA0:  cmd.op = OP_EMA0;
      S_EMA1:  cmd.op = OP_EMA1;
      S_UPD:   cmd.op = OP_UPD;
      S_SC0:   cmd.op = OP_SC0;
      S_SC1:   cmd.op = OP_SC1;
      S_SC2:   cmd.op = OP_SC2;
      S_DIV:   cmd.op = OP_DIV;
      S_EMIT:  cmd.op = emit_go ? OP_EMIT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_MUL0;
        S_MUL0: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MUL3;
        S_MUL3: state <= S_MUL4;
        S_MUL4: state <= S_PREP;
        S_PREP: state <= st.degen ? S_FIN : S_NORM;
        S_NORM: begin
          if (st.norm_done) begin
            state <= S_ROT;
            step  <= '0;
          end
        end
        S_ROT: begin
          if (step == ROT_LAST) begin
            state <= S_FIN;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FIN:  state <= S_EMA0;
        S_EMA0: state <= S_EMA1;
        S_EMA1: state <= S_UPD;
        S_UPD:  state <= S_SC0;
        S_SC0:  state <= S_SC1;
        S_SC1:  state <= S_SC2;
        S_SC2: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == DIV_LAST) begin
            state <= S_EMIT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `JART_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_MUL0, "frame did not start")
  `JART_ASSERT_IMPL(a_rot_bound, state == S_ROT, step <= ROT_LAST, "rotation step overrun")
  `JART_ASSERT_IMPL(a_div_bound, state == S_DIV, step <= DIV_LAST, "divide step overrun")
  `JART_ASSERT_NEXT(a_emit_loads, emit_go, out_valid && state == S_IDLE, "result not posted")

endmodule
`default_nettype wire

@@ rtl/joint_angle_rep_phase_tracker.sv @@
// Joint-angle rep tracker. One frame in on in_ch (three joint points and a
// millisecond timestamp), one result out on out_ch per frame, in order.
// Both channels transfer on a clock edge with valid and ready high.
// Registers are written through the APB port (byte address 4*index, no wait
// states); write them only while no frame is in flight.
// A frame runs through the multiply states, a setup state, the normalize state
// (repeated until the vector is scaled up), the rotation steps (CORDIC_STEPS,
// at most ATAN_LEN), the smoothing, tracking and scoring states, the divide
// steps for the form score and a final state to post the result.
// A frame with a point on the vertex skips normalize and rotation.
// The multiplier is shared, there is a single CORDIC stage and the divider is
// bit-serial; one frame is worked on at a time, and the next frame is taken
// the cycle after the previous result is posted to the output register.
// If the receiver stalls, the result holds in the output register while the
// next frame is processed; that frame waits to post until the register frees.
// Reset (rst, synchronous) clears the phase machine, the filter, the counters
// and the last score and loads the register defaults.
`default_nettype none
module joint_angle_rep_phase_tracker import jart_pkg::*; #(
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  jart_in_if.sink     in_ch,
  jart_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  cmd_t      cmd;
  status_t   st;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item = '{first_x: in_ch.first_x, first_y: in_ch.first_y,
                     vertex_x: in_ch.vertex_x, vertex_y: in_ch.vertex_y,
                     third_x: in_ch.third_x, third_y: in_ch.third_y,
                     time_ms: in_ch.time_ms};

  assign out_ch.rep_done        = out_item.rep_done;
  assign out_ch.rep_count       = out_item.rep_count;
  assign out_ch.phase           = out_item.phase;
  assign out_ch.smoothed_angle  = out_item.smoothed_angle;
  assign out_ch.peak_angle      = out_item.peak_angle;
  assign out_ch.start_angle     = out_item.start_angle;
  assign out_ch.rep_duration_ms = out_item.rep_duration_ms;
  assign out_ch.quality_score   = out_item.quality_score;
  assign out_ch.form_rating     = out_item.form_rating;

  jart_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jart_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  jart_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_item  (in_item),
    .st       (st),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

@@ test/tb_joint_angle_rep_phase_tracker.sv @@
`default_nettype none
module tb_joint_angle_rep_phase_tracker;
  import jart_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam real PI = 3.14159265358979;
  localparam longint ATAN_TAB [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  jart_in_if  in_ch();
  jart_out_if out_ch();

  joint_angle_rep_phase_tracker DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // tracker state mirror
  cfg_t          cfg;
  phase_t        ph;
  longint        filt;
  bit            seeded;
  int            start_a;
  int            peak_a;
  bit [31:0]     t_start;
  int unsigned   dur;
  int unsigned   reps;
  int unsigned   score;
  rating_t       rating;

  out_item_t     expected_q[$];
  int            errors;
  int            n_frames;
  int            n_done;
  int            n_cfg;
  int            cycles;
  bit            quiet;
  int            stall_left;
  bit [31:0]     now_ms;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned joint_deg10(in_item_t it);
    longint ux, uy, vx, vy, x, y, z, t, xs, ys;
    ux = longint'($signed(it.first_x)) - longint'($signed(it.vertex_x));
    uy = longint'($signed(it.first_y)) - longint'($signed(it.vertex_y));
    vx = longint'($signed(it.third_x)) - longint'($signed(it.vertex_x));
    vy = longint'($signed(it.third_y)) - longint'($signed(it.vertex_y));
    x = ux * vx + uy * vy;
    y = ux * vy - uy * vx;
    z = 0;
    if (y < 0) y = -y;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 90 * 65536;
    end
    while (x < (64'sd1 <<< 40) && y < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    z = (z * 10 + 32768) >>> 16;
    if (z > 1800) z = 1800;
    return int'(z);
  endfunction

  function automatic int ema_angle(int unsigned raw);
    longint a;
    longint s;
    a = (cfg.alpha > 256) ? 256 : longint'(cfg.alpha);
    if (!seeded) begin
      filt = longint'(raw) * 256;
      seeded = 1'b1;
    end else begin
      filt = filt + ((a * (longint'(raw) * 256 - filt) + 128) >>> 8);
    end
    if (filt < 0) filt = 0;
    if (filt > 1800 * 256) filt = 1800 * 256;
    s = (filt + 128) >>> 8;
    return (s > 1800) ? 1800 : int'(s);
  endfunction

  function automatic void grade_rep(bit [31:0] elapsed);
    longint unsigned ach, tgt, tempo, num;
    int d, r;
    d = start_a - peak_a;
    r = int'(cfg.ext) - int'(cfg.cont);
    ach = (d < 0) ? -d : d;
    tgt = (r < 0) ? -r : r;
    if (tgt == 0) begin
      tgt = 1;
      ach = 1;
    end
    if (ach > tgt) ach = tgt;
    tempo = (elapsed < 1200) ? 400 : ((elapsed > 5000) ? 425 : 500);
    num = 1500 * ach + tempo * tgt;
    score = int'((num + tgt) / (2 * tgt));
    if (score > 1000) score = 1000;
    if (num < 1400 * tgt) rating = RT_PARTIAL;
    else if (num < 1700 * tgt) rating = RT_GOOD;
    else rating = RT_PERFECT;
  endfunction

  function automatic out_item_t track_frame(in_item_t it);
    out_item_t r;
    int a, ext, cont;
    bit inv, done;
    bit [31:0] elapsed;
    a = ema_angle(joint_deg10(it));
    ext = int'(cfg.ext);
    cont = int'(cfg.cont);
    inv = cont > ext;
    elapsed = it.time_ms - t_start;
    done = 1'b0;
    if (ph != PH_START) dur = (elapsed > 32'hFFFF) ? 32'hFFFF : elapsed;
    case (ph)
      PH_START: begin
        if (inv ? (a <= ext + 100) : (a >= ext - 100)) begin
          start_a = a;
          peak_a = a;
        end
        if (inv ? (a > ext + 150) : (a < ext - 150)) begin
          ph = PH_MOVING;
          t_start = it.time_ms;
          peak_a = a;
        end
      end
      PH_MOVING: begin
        if (inv ? (a > peak_a) : (a < peak_a)) peak_a = a;
        if (inv ? (a >= cont) : (a <= cont)) ph = PH_INFLECTION;
        else if (elapsed > cfg.max_ms) ph = PH_START;
      end
      PH_INFLECTION: begin
        if (inv ? (a > peak_a) : (a < peak_a)) peak_a = a;
        if (inv ? (a < cont - 120) : (a > cont + 120)) ph = PH_RETURNING;
      end
      default: begin
        if (inv ? (a <= ext + int'(cfg.rom)) : (a >= ext - int'(cfg.rom))) begin
          if (elapsed >= cfg.min_ms) begin
            if (reps < 65535) reps++;
            done = 1'b1;
            grade_rep(elapsed);
          end
          ph = PH_START;
        end else if (elapsed > cfg.max_ms) begin
          ph = PH_START;
        end
      end
    endcase
    r.rep_done = done;
    r.rep_count = reps[15:0];
    r.phase = ph;
    r.smoothed_angle = a[10:0];
    r.peak_angle = peak_a[10:0];
    r.start_angle = start_a[10:0];
    r.rep_duration_ms = dur[15:0];
    r.quality_score = score[9:0];
    r.form_rating = rating;
    return r;
  endfunction

  // output side: random stalls and result checking
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic field_check(string name, longint unsigned e, longint unsigned g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, g);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got phase %0d",
                 $time, out_ch.phase);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.rep_done === 1'b1) n_done++;
        field_check("rep_done", e.rep_done, out_ch.rep_done);
        field_check("rep_count", e.rep_count, out_ch.rep_count);
        field_check("phase", e.phase, out_ch.phase);
        field_check("smoothed_angle", e.smoothed_angle, out_ch.smoothed_angle);
        field_check("peak_angle", e.peak_angle, out_ch.peak_angle);
        field_check("start_angle", e.start_angle, out_ch.start_angle);
        field_check("rep_duration_ms", e.rep_duration_ms, out_ch.rep_duration_ms);
        field_check("quality_score", e.quality_score, out_ch.quality_score);
        field_check("form_rating", e.form_rating, out_ch.form_rating);
      end
    end
  end

  task automatic send_frame(in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_x <= it.first_x;
    in_ch.first_y <= it.first_y;
    in_ch.vertex_x <= it.vertex_x;
    in_ch.vertex_y <= it.vertex_y;
    in_ch.third_x <= it.third_x;
    in_ch.third_y <= it.third_y;
    in_ch.time_ms <= it.time_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_q.push_back(track_frame(it));
    n_frames++;
  endtask

  task automatic send_points(int fx, int fy, int vx, int vy, int tx, int ty,
                             bit [31:0] tms);
    in_item_t it;
    it.first_x = fx[15:0];
    it.first_y = fy[15:0];
    it.vertex_x = vx[15:0];
    it.vertex_y = vy[15:0];
    it.third_x = tx[15:0];
    it.third_y = ty[15:0];
    it.time_ms = tms;
    send_frame(it);
  endtask

  task automatic send_pose(int ang10, bit [31:0] tms);
    real phi, th, len;
    int vx, vy;
    if (ang10 < 0) ang10 = 0;
    if (ang10 > 1800) ang10 = 1800;
    phi = $urandom_range(0, 6283) / 1000.0;
    th = ang10 * PI / 1800.0;
    len = $urandom_range(500, 12000);
    vx = $urandom_range(0, 30000) - 15000;
    vy = $urandom_range(0, 30000) - 15000;
    send_points(vx + int'(len * $cos(phi)), vy + int'(len * $sin(phi)), vx, vy,
                vx + int'(len * $cos(phi + th)), vy + int'(len * $sin(phi + th)), tms);
  endtask

  task automatic send_noise();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom};
    send_frame(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t r, int unsigned v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_EXT:   cfg.ext = v[10:0];
      REG_CONT:  cfg.cont = v[10:0];
      REG_MIN:   cfg.min_ms = v[15:0];
      REG_MAX:   cfg.max_ms = v[15:0];
      REG_ROM:   cfg.rom = v[10:0];
      default:   cfg.alpha = v[8:0];
    endcase
  endtask

  task automatic set_config(int unsigned e, int unsigned c, int unsigned mn, int unsigned mx,
                            int unsigned rom, int unsigned al);
    drain();
    reg_write(REG_EXT, e);
    reg_write(REG_CONT, c);
    reg_write(REG_MIN, mn);
    reg_write(REG_MAX, mx);
    reg_write(REG_ROM, rom);
    reg_write(REG_ALPHA, al);
    n_cfg++;
  endtask

  // one movement from the extension side to the contraction side and back
  task automatic send_rep();
    int e_ang, c_ang, nf, dt, hold, ang, span;
    bit inv;
    inv = cfg.cont > cfg.ext;
    e_ang = inv ? int'(cfg.ext) - $urandom_range(0, 80) : int'(cfg.ext) + $urandom_range(0, 80);
    span = int'(cfg.cont) - e_ang;
    c_ang = e_ang + span + (inv ? 1 : -1) * $urandom_range(0, 150);
    if ($urandom_range(0, 4) == 0) c_ang = e_ang + (span * int'($urandom_range(30, 90))) / 100;
    nf = $urandom_range(3, 10);
    hold = $urandom_range(1, 5);
    dt = $urandom_range(20, 600) / nf;
    if ($urandom_range(0, 9) == 0) dt = $urandom_range(500, 3000);
    for (int i = 0; i < 3 + 2 * nf + 2 * hold; i++) begin
      if (i < hold + 1) ang = e_ang;
      else if (i < hold + 1 + nf) ang = e_ang + (c_ang - e_ang) * (i - hold) / nf;
      else if (i < 2 * hold + 1 + nf) ang = c_ang;
      else if (i < 2 * hold + 1 + 2 * nf) ang = c_ang + (e_ang - c_ang) * (i - 2 * hold - nf) / nf;
      else ang = e_ang;
      now_ms += dt + $urandom_range(0, 10);
      send_pose(ang + $urandom_range(0, 20) - 10, now_ms);
    end
  endtask

  task automatic random_stream(int count);
    int start_n;
    start_n = n_frames;
    now_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 : $urandom;
    while (n_frames - start_n < count) begin
      if ($urandom_range(0, 9) < 8) send_rep();
      else send_noise();
    end
  endtask

  task automatic test_corner_frames();
    send_points(-32768, -32768, -32768, -32768, -32768, -32768, 32'h0);
    send_points(32767, 32767, -32768, -32768, 32767, -32768, 32'hFFFF_FFFF);
    send_points(-32768, 32767, 32767, -32768, 32767, 32767, 32'h8000_0000);
    send_points(-1000, 0, 0, 0, 1000, 0, 32'd100);
    send_points(5000, 5000, 0, 0, 2500, 2500, 32'd200);
    send_points(0, 3000, 0, 0, 3000, 0, 32'd300);
    send_points(-3000, 100, 0, 0, 3000, 200, 32'd400);
    send_points(17, -9, 17, -9, 400, 400, 32'd500);
    send_points(400, 400, -5, 5, -5, 5, 32'd600);
    send_points(1, 0, 0, 0, -1, 1, 32'd700);
    send_points(32767, 0, -32768, 0, -32768, 32767, 32'h7FFF_FFFF);
    now_ms = 32'hFFFF_FE00;
    for (int i = 0; i < 12; i++) begin
      now_ms += 100;
      send_pose(i < 3 ? 1700 : (i < 7 ? 400 : 1650), now_ms);
    end
    drain();
  endtask

  task automatic test_default_reps();
    random_stream(350);
  endtask

  task automatic test_extreme_config();
    set_config(1800, 0, 0, 65535, 1800, 256);
    random_stream(350);
  endtask

  task automatic test_inverted();
    set_config(300, 1500, 750, 8000, 100, 511);
    random_stream(350);
  endtask

  task automatic test_flat_range();
    set_config(900, 900, 200, 3000, 0, 128);
    random_stream(250);
  endtask

  task automatic test_limits();
    set_config(0, 1800, 65535, 0, 0, 0);
    random_stream(120);
    set_config(1800, 1800, 65535, 65535, 1800, 1);
    random_stream(60);
  endtask

  task automatic test_final_stream();
    set_config(1600, 400, 500, 6000, 200, 180);
    quiet = 1'b1;
    random_stream(450);
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.first_x <= '0;
    in_ch.first_y <= '0;
    in_ch.vertex_x <= '0;
    in_ch.vertex_y <= '0;
    in_ch.third_x <= '0;
    in_ch.third_y <= '0;
    in_ch.time_ms <= '0;
    errors = 0;
    n_frames = 0;
    n_done = 0;
    n_cfg = 0;
    quiet = 1'b0;
    cfg = '{ext: 11'd1500, cont: 11'd550, min_ms: 16'd750, max_ms: 16'd8000,
            rom: 11'd150, alpha: 9'd115};
    ph = PH_START;
    filt = 0;
    seeded = 1'b0;
    start_a = 0;
    peak_a = 0;
    t_start = '0;
    dur = 0;
    reps = 0;
    score = 0;
    rating = RT_PERFECT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_frames();
    test_default_reps();
    test_extreme_config();
    test_inverted();
    test_flat_range();
    test_limits();
    test_final_stream();
    drain();
    $display("covered %0d frames over %0d register settings, %0d completed reps seen",
             n_frames, n_cfg + 1, n_done);
    $display("phase machine, inversion, flat range, timeouts and scoring exercised");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
